// ===== sv/stt_pkg.sv =====
// Package for the space-time reservation table: sizes, codes, the cell control
// struct and small helpers for keys and footprint offsets.
// No dependencies.
package stt_pkg;

	localparam int TABLE_ENTRIES = 256;
	localparam int MAX_CLEARANCE = 3;
	localparam int XY_W          = 20;
	localparam int T_W           = 24;
	localparam int KEY_W         = 2 * XY_W + T_W;
	localparam int AGENT_W       = 16;
	localparam int PRI_W         = 16;
	localparam int TICK_W        = 32;
	localparam int COST_W        = 16;
	localparam int OFS_W         = 4;
	localparam int COUNT_W       = 9;
	localparam int GROUP         = 16;
	localparam int GROUPS        = TABLE_ENTRIES / GROUP;
	localparam int GRP_CNT_W     = $clog2(GROUP + 1);
	// reciprocal of ten, exact for 16-bit operands
	localparam int DIV10_MUL     = 52429;
	localparam int DIV10_SHIFT   = 19;

	localparam logic [2:0] CMD_RESERVE = 3'd0;
	localparam logic [2:0] CMD_RELEASE = 3'd1;
	localparam logic [2:0] CMD_PENALTY = 3'd2;
	localparam logic [2:0] CMD_VERTEX  = 3'd3;
	localparam logic [2:0] CMD_EDGE    = 3'd4;
	localparam logic [2:0] CMD_CLEANUP = 3'd5;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_CONFLICT = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_SKIPPED  = 2'd3;

	localparam logic [1:0] REG_CLEARANCE = 2'd0;
	localparam logic [1:0] REG_COOP      = 2'd1;
	localparam logic [1:0] REG_STALE     = 2'd2;
	localparam logic [1:0] REG_COST      = 2'd3;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [AGENT_W-1:0] wr_agent;
		logic [PRI_W-1:0]   wr_pri;
		logic [TICK_W-1:0]  wr_stamp;
		logic               wr_en;
		logic               del_en;
		logic               sweep_en;
		logic [TICK_W-1:0]  now;
		logic [TICK_W-1:0]  limit;
	} cell_ctl_t;

	function automatic logic [KEY_W-1:0] mk_key(input logic [XY_W-1:0] x,
		input logic [XY_W-1:0] y, input logic [T_W-1:0] t);
		return {x, y, t};
	endfunction

	function automatic logic [XY_W-1:0] ofs_add(input logic [XY_W-1:0] x,
		input logic [OFS_W-1:0] o);
		logic [XY_W-1:0] ext;
		ext = {{(XY_W-OFS_W){o[OFS_W-1]}}, o};
		return x + ext;
	endfunction

	function automatic logic [OFS_W-1:0] clamp_clr(input logic [1:0] c);
		if (int'(c) > MAX_CLEARANCE) begin
			return OFS_W'(MAX_CLEARANCE);
		end
		return OFS_W'(c);
	endfunction

endpackage

// ===== sv/space_time_reservation_table_top.sv =====
// Space-time reservation table top level: sequencer, configuration registers and
// the row of entry cells. Depends on stt_pkg and stt_cell.
//
// The table is a row of 256 cells, each holding one (x, y, t) reservation and
// comparing its key against a broadcast key every cycle. One transaction at a
// time is processed. Every footprint cell visited goes through the steps drive
// key, compare in all cells, collect the matching entry and act. A reserve,
// release or vertex query visits the (2c+1)^2 cells of clearance c, a penalty
// query the single cell, and an edge query in the worst case also walks the
// (2c+1)^2 origin cells at t+1 for each occupied destination cell; a conflict
// or a full table ends the walk early. Cleanup checks all cells at once. A
// reserve on a path that already failed answers without a walk. The result sits
// in an output register, so a new transaction is taken as soon as the sequencer is idle.
module space_time_reservation_table_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    cmd,
	input  logic signed [stt_pkg::XY_W-1:0] cell_x,
	input  logic signed [stt_pkg::XY_W-1:0] cell_y,
	input  logic signed [stt_pkg::T_W-1:0]  cell_t,
	input  logic signed [stt_pkg::XY_W-1:0] to_x,
	input  logic signed [stt_pkg::XY_W-1:0] to_y,
	input  logic [stt_pkg::AGENT_W-1:0]   agent_id,
	input  logic [stt_pkg::PRI_W-1:0]     priority_req,
	input  logic [stt_pkg::TICK_W-1:0]    now,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic                          conflict,
	output logic [stt_pkg::COST_W-1:0]    penalty,
	output logic                          path_ok,
	output logic [stt_pkg::COUNT_W-1:0]   removed_count,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [31:0]                   cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_ADDR, S_CMP, S_RD, S_ACT, S_CL1, S_CL2, S_CL3, S_DONE
	} state_t;

	localparam int N = stt_pkg::TABLE_ENTRIES;

	state_t state_q;

	// configuration
	logic [1:0]                  clr_cfg_q;
	logic                        coop_q;
	logic [stt_pkg::TICK_W-1:0]  limit_q;
	logic [stt_pkg::COST_W-1:0]  cost_q;
	logic [stt_pkg::COST_W-1:0]  cost10;
	logic [stt_pkg::COST_W+17-1:0] cost_prod;

	// transaction fields
	logic [2:0]                   cmd_q;
	logic [stt_pkg::XY_W-1:0]     px_q, py_q, qx_q, qy_q;
	logic [stt_pkg::T_W-1:0]      pt_q, qt_q;
	logic [stt_pkg::AGENT_W-1:0]  agent_q;
	logic [stt_pkg::PRI_W-1:0]    pri_q;
	logic [stt_pkg::TICK_W-1:0]   now_q;
	logic                         last_q;
	logic [stt_pkg::OFS_W-1:0]    c_q;
	logic [stt_pkg::OFS_W-1:0]    o1x_q, o1y_q, o2x_q, o2y_q;
	logic                         inner_q;
	logic [stt_pkg::AGENT_W-1:0]  i_agent_q;
	logic [stt_pkg::PRI_W-1:0]    i_pri_q;
	logic                         path_failed_q;
	logic [stt_pkg::KEY_W-1:0]    bkey_q;

	// collected lookup
	logic                         rd_found_q;
	logic [stt_pkg::AGENT_W-1:0]  rd_agent_q;
	logic [stt_pkg::PRI_W-1:0]    rd_pri_q;
	logic [N-1:0]                 free_q;
	logic                         free_any_q;
	logic [stt_pkg::GRP_CNT_W-1:0] grp_q [stt_pkg::GROUPS];

	// result under construction and output register
	logic [1:0]                   res_status_q;
	logic                         res_conf_q;
	logic [stt_pkg::COST_W-1:0]   res_pen_q;
	logic [stt_pkg::COUNT_W-1:0]  res_rem_q;
	logic                         out_valid_q;
	logic [1:0]                   status_q;
	logic                         conflict_q;
	logic [stt_pkg::COST_W-1:0]   penalty_q;
	logic                         path_ok_q;
	logic [stt_pkg::COUNT_W-1:0]  removed_q;

	// cell row
	stt_pkg::cell_ctl_t           ctl;
	logic [N-1:0]                 hit_vec, stale_vec, valid_vec, sel_vec;
	logic [stt_pkg::AGENT_W-1:0]  cell_agent [N];
	logic [stt_pkg::PRI_W-1:0]    cell_pri [N];

	logic                         in_acc;
	logic [stt_pkg::OFS_W-1:0]    c_in, neg_c;
	logic                         own, steal, claim, ignore_i, o1_end, o2_end;
	logic                         res_fail, v_hit, e_hit, e_enter, e_step, act_stop;
	logic [stt_pkg::AGENT_W-1:0]  or_agent;
	logic [stt_pkg::PRI_W-1:0]    or_pri;
	logic [stt_pkg::COUNT_W-1:0]  grp_sum;
	logic [stt_pkg::OFS_W-1:0]    o1x_n, o1y_n, o2x_n, o2y_n;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	// a penalty query looks at the single cell only
	assign c_in  = (cmd == stt_pkg::CMD_PENALTY) ? '0 : stt_pkg::clamp_clr(clr_cfg_q);
	assign neg_c = ~c_q + stt_pkg::OFS_W'(1);

	assign cost_prod = cost_q * 17'(stt_pkg::DIV10_MUL);
	assign cost10    = stt_pkg::COST_W'(cost_prod >> stt_pkg::DIV10_SHIFT);

	// decisions on the collected entry
	assign own      = (rd_agent_q == agent_q);
	assign steal    = rd_found_q && !own && (pri_q < rd_pri_q);
	assign claim    = !rd_found_q && free_any_q;
	assign ignore_i = coop_q && (pri_q >= rd_pri_q);

	// reserve stops on a foreign cell it cannot steal or on a full table
	assign res_fail = (cmd_q == stt_pkg::CMD_RESERVE)
		&& ((rd_found_q && !own && !steal) || (!rd_found_q && !free_any_q));
	assign v_hit    = (cmd_q == stt_pkg::CMD_VERTEX) && rd_found_q && !own && !ignore_i;
	// swap: the same foreign agent holds the destination at t and the origin at t+1
	assign e_hit    = (cmd_q == stt_pkg::CMD_EDGE) && inner_q && rd_found_q
		&& (rd_agent_q == i_agent_q) && (i_agent_q != agent_q)
		&& !(coop_q && (pri_q >= i_pri_q));
	assign e_enter  = (cmd_q == stt_pkg::CMD_EDGE) && !inner_q && rd_found_q;
	assign e_step   = (cmd_q == stt_pkg::CMD_EDGE) && inner_q && !o2_end;
	assign act_stop = res_fail || v_hit || e_hit;

	assign o1_end = (o1x_q == c_q) && (o1y_q == c_q);
	assign o2_end = (o2x_q == c_q) && (o2y_q == c_q);
	// raster order: y inner, x outer
	assign o1y_n = (o1y_q == c_q) ? neg_c : o1y_q + stt_pkg::OFS_W'(1);
	assign o1x_n = (o1y_q == c_q) ? o1x_q + stt_pkg::OFS_W'(1) : o1x_q;
	assign o2y_n = (o2y_q == c_q) ? neg_c : o2y_q + stt_pkg::OFS_W'(1);
	assign o2x_n = (o2y_q == c_q) ? o2x_q + stt_pkg::OFS_W'(1) : o2x_q;

	always_comb begin
		ctl.key      = bkey_q;
		ctl.wr_agent = agent_q;
		ctl.wr_pri   = pri_q;
		ctl.wr_stamp = now_q;
		ctl.wr_en    = (state_q == S_ACT) && (cmd_q == stt_pkg::CMD_RESERVE) && (steal || claim);
		ctl.del_en   = (state_q == S_ACT) && (cmd_q == stt_pkg::CMD_RELEASE) && rd_found_q && own;
		ctl.sweep_en = (state_q == S_CL2);
		ctl.now      = now_q;
		ctl.limit    = limit_q;
		sel_vec      = claim ? free_q : hit_vec;
	end

	// keys are unique among valid entries, so an OR over the hits picks the entry
	always_comb begin
		or_agent = '0;
		or_pri   = '0;
		for (int i = 0; i < N; i++) begin
			or_agent = or_agent | (cell_agent[i] & {stt_pkg::AGENT_W{hit_vec[i]}});
			or_pri   = or_pri | (cell_pri[i] & {stt_pkg::PRI_W{hit_vec[i]}});
		end
	end

	always_comb begin
		grp_sum = '0;
		for (int g = 0; g < stt_pkg::GROUPS; g++) begin
			grp_sum = grp_sum + stt_pkg::COUNT_W'(grp_q[g]);
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < N; gi++) begin : g_cell
			stt_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.sel    (sel_vec[gi]),
				.hit    (hit_vec[gi]),
				.stale  (stale_vec[gi]),
				.valid  (valid_vec[gi]),
				.agent  (cell_agent[gi]),
				.pri    (cell_pri[gi])
			);
		end
	endgenerate

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cfg_q <= 2'd0;
			coop_q    <= 1'b1;
			limit_q   <= 32'd30000;
			cost_q    <= 16'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				stt_pkg::REG_CLEARANCE: clr_cfg_q <= cfg_data[1:0];
				stt_pkg::REG_COOP:      coop_q    <= cfg_data[0];
				stt_pkg::REG_STALE:     limit_q   <= cfg_data;
				stt_pkg::REG_COST:      cost_q    <= cfg_data[stt_pkg::COST_W-1:0];
				default: ;
			endcase
		end
	end

	// transaction payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q   <= cmd;
			// offset form: flip the sign bit
			px_q    <= (cmd == stt_pkg::CMD_EDGE) ? {~to_x[stt_pkg::XY_W-1], to_x[stt_pkg::XY_W-2:0]}
			                                      : {~cell_x[stt_pkg::XY_W-1], cell_x[stt_pkg::XY_W-2:0]};
			py_q    <= (cmd == stt_pkg::CMD_EDGE) ? {~to_y[stt_pkg::XY_W-1], to_y[stt_pkg::XY_W-2:0]}
			                                      : {~cell_y[stt_pkg::XY_W-1], cell_y[stt_pkg::XY_W-2:0]};
			pt_q    <= {~cell_t[stt_pkg::T_W-1], cell_t[stt_pkg::T_W-2:0]};
			qx_q    <= {~cell_x[stt_pkg::XY_W-1], cell_x[stt_pkg::XY_W-2:0]};
			qy_q    <= {~cell_y[stt_pkg::XY_W-1], cell_y[stt_pkg::XY_W-2:0]};
			qt_q    <= {~cell_t[stt_pkg::T_W-1], cell_t[stt_pkg::T_W-2:0]} + stt_pkg::T_W'(1);
			agent_q <= agent_id;
			pri_q   <= priority_req;
			now_q   <= now;
			last_q  <= last;
			c_q     <= c_in;
		end
		if (state_q == S_ADDR) begin
			bkey_q <= inner_q
				? stt_pkg::mk_key(stt_pkg::ofs_add(qx_q, o2x_q), stt_pkg::ofs_add(qy_q, o2y_q), qt_q)
				: stt_pkg::mk_key(stt_pkg::ofs_add(px_q, o1x_q), stt_pkg::ofs_add(py_q, o1y_q), pt_q);
		end
		if (state_q == S_RD) begin
			rd_agent_q <= or_agent;
			rd_pri_q   <= or_pri;
			free_q     <= ~valid_vec & (valid_vec + N'(1));
		end
		if (state_q == S_CL2) begin
			for (int g = 0; g < stt_pkg::GROUPS; g++) begin
				grp_q[g] <= stt_pkg::GRP_CNT_W'($countones(stale_vec[g*stt_pkg::GROUP +: stt_pkg::GROUP]));
			end
		end
		if (state_q == S_ACT && cmd_q == stt_pkg::CMD_EDGE && !inner_q) begin
			i_agent_q <= rd_agent_q;
			i_pri_q   <= rd_pri_q;
		end
		if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
			status_q   <= res_status_q;
			conflict_q <= res_conf_q;
			penalty_q  <= res_pen_q;
			path_ok_q  <= (cmd_q == stt_pkg::CMD_RESERVE) && last_q && !path_failed_q;
			removed_q  <= res_rem_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			path_failed_q <= 1'b0;
			out_valid_q   <= 1'b0;
			inner_q       <= 1'b0;
			rd_found_q    <= 1'b0;
			free_any_q    <= 1'b0;
			o1x_q         <= '0;
			o1y_q         <= '0;
			o2x_q         <= '0;
			o2y_q         <= '0;
			res_status_q  <= stt_pkg::ST_OK;
			res_conf_q    <= 1'b0;
			res_pen_q     <= '0;
			res_rem_q     <= '0;
		end else begin
			// load the output register when free, drop the result once taken
			if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						res_status_q <= (cmd == stt_pkg::CMD_RESERVE && path_failed_q)
							? stt_pkg::ST_SKIPPED : stt_pkg::ST_OK;
						res_conf_q   <= 1'b0;
						res_pen_q    <= '0;
						res_rem_q    <= '0;
						inner_q      <= 1'b0;
						o1x_q        <= ~c_in + stt_pkg::OFS_W'(1);
						o1y_q        <= ~c_in + stt_pkg::OFS_W'(1);
						case (cmd)
							stt_pkg::CMD_RESERVE: begin
								state_q <= path_failed_q ? S_DONE : S_ADDR;
							end
							stt_pkg::CMD_RELEASE, stt_pkg::CMD_PENALTY,
							stt_pkg::CMD_VERTEX, stt_pkg::CMD_EDGE: state_q <= S_ADDR;
							stt_pkg::CMD_CLEANUP: state_q <= S_CL1;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_ADDR: state_q <= S_CMP;
				S_CMP:  state_q <= S_RD;
				S_RD: begin
					rd_found_q <= |hit_vec;
					free_any_q <= ~&valid_vec;
					state_q    <= S_ACT;
				end
				S_ACT: begin
					case (cmd_q)
						stt_pkg::CMD_RESERVE: begin
							if (res_fail) begin
								res_status_q  <= rd_found_q ? stt_pkg::ST_CONFLICT : stt_pkg::ST_FULL;
								path_failed_q <= 1'b1;
							end
						end
						stt_pkg::CMD_RELEASE: begin
							if (rd_found_q && own) begin
								res_rem_q <= res_rem_q + stt_pkg::COUNT_W'(1);
							end
						end
						stt_pkg::CMD_PENALTY: begin
							if (rd_found_q && !own) begin
								res_pen_q <= (pri_q < rd_pri_q) ? cost10 : cost_q;
							end
						end
						stt_pkg::CMD_VERTEX: begin
							if (v_hit) begin
								res_conf_q <= 1'b1;
							end
						end
						stt_pkg::CMD_EDGE: begin
							if (e_hit) begin
								res_conf_q <= 1'b1;
							end
						end
						default: ;
					endcase
					if (act_stop) begin
						state_q <= S_DONE;
					end else if (e_enter) begin
						// occupied destination cell: walk the origin footprint at t+1
						inner_q <= 1'b1;
						o2x_q   <= neg_c;
						o2y_q   <= neg_c;
						state_q <= S_ADDR;
					end else if (e_step) begin
						o2x_q   <= o2x_n;
						o2y_q   <= o2y_n;
						state_q <= S_ADDR;
					end else begin
						// advance the primary footprint
						inner_q <= 1'b0;
						if (o1_end) begin
							state_q <= S_DONE;
						end else begin
							o1x_q   <= o1x_n;
							o1y_q   <= o1y_n;
							state_q <= S_ADDR;
						end
					end
				end
				S_CL1: state_q <= S_CL2;
				S_CL2: state_q <= S_CL3;
				S_CL3: begin
					res_rem_q <= grp_sum;
					state_q   <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						if (cmd_q == stt_pkg::CMD_RESERVE && last_q) begin
							path_failed_q <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign conflict      = conflict_q;
	assign penalty       = penalty_q;
	assign path_ok       = path_ok_q;
	assign removed_count = removed_q;

	// a key lives in at most one valid entry
	a_hit_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("key matched in more than one entry");

	// a new claim goes to exactly one free slot
	a_claim_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.wr_en && claim) |-> $onehot(free_q))
		else $error("claim without a single free slot");

	// a good path ends on an ok status
	a_path_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && path_ok) |-> (status == stt_pkg::ST_OK))
		else $error("path_ok with failing status");

endmodule

// ===== sv/stt_cell.sv =====
// One table entry: key, owner, priority and stamp, with its own key compare
// and staleness check. Depends on stt_pkg.
module stt_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  stt_pkg::cell_ctl_t        ctl,
	input  logic                      sel,
	output logic                      hit,
	output logic                      stale,
	output logic                      valid,
	output logic [stt_pkg::AGENT_W-1:0] agent,
	output logic [stt_pkg::PRI_W-1:0]   pri
);

	logic                         valid_q;
	logic                         hit_q;
	logic                         stale_q;
	logic [stt_pkg::KEY_W-1:0]    key_q;
	logic [stt_pkg::AGENT_W-1:0]  agent_q;
	logic [stt_pkg::PRI_W-1:0]    pri_q;
	logic [stt_pkg::TICK_W-1:0]   stamp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
			stale_q <= 1'b0;
		end else begin
			hit_q   <= valid_q && (key_q == ctl.key);
			stale_q <= valid_q && (stamp_q <= ctl.now) && ((ctl.now - stamp_q) > ctl.limit);
			if (ctl.wr_en && sel) begin
				valid_q <= 1'b1;
			end else if ((ctl.del_en && sel) || (ctl.sweep_en && stale_q)) begin
				valid_q <= 1'b0;
			end
		end
	end

	// payload: no reset, only read while valid
	always_ff @(posedge clk) begin
		if (ctl.wr_en && sel) begin
			key_q   <= ctl.key;
			agent_q <= ctl.wr_agent;
			pri_q   <= ctl.wr_pri;
			stamp_q <= ctl.wr_stamp;
		end
	end

	assign hit   = hit_q;
	assign stale = stale_q;
	assign valid = valid_q;
	assign agent = agent_q;
	assign pri   = pri_q;

endmodule
